// ----- rtl/apcs_pkg.sv -----
// ----------------------------------------------------------------------------
// apcs_pkg
// Shared widths, codes and controller/datapath interface types for the
// automaton prefix completion scan.
// ----------------------------------------------------------------------------
package apcs_pkg;

    localparam int ADDR_W   = 12;                       // store entry address
    localparam int LETTER_W = 16;
    localparam int ENTRY_W  = LETTER_W + ADDR_W + 2;    // {final, last, target, letter}
    localparam int DEPTH    = 64;                       // path stack entries
    localparam int PIDX_W   = $clog2(DEPTH);
    localparam int DEPTH_W  = PIDX_W + 1;               // holds DEPTH itself
    localparam int POS_W    = 7;

    // operations
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_SYMBOL = 3'd1;
    localparam logic [2:0] OP_FIRST  = 3'd2;
    localparam logic [2:0] OP_NEXT   = 3'd3;
    localparam logic [2:0] OP_START  = 3'd4;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_LETTER   = 3'd2;
    localparam logic [2:0] ST_NOMORE   = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // datapath actions
    localparam logic [4:0] A_NONE        = 5'd0;
    localparam logic [4:0] A_LOAD        = 5'd1;
    localparam logic [4:0] A_WRITE       = 5'd2;
    localparam logic [4:0] A_START       = 5'd3;
    localparam logic [4:0] A_SETFAIL     = 5'd4;
    localparam logic [4:0] A_RD_PD       = 5'd5;
    localparam logic [4:0] A_RD_TOP      = 5'd6;
    localparam logic [4:0] A_E_PDATA     = 5'd7;
    localparam logic [4:0] A_SCAN_MATCH  = 5'd8;
    localparam logic [4:0] A_SCAN_NEXT   = 5'd9;
    localparam logic [4:0] A_DESC_STEP   = 5'd10;
    localparam logic [4:0] A_DESC_FOLLOW = 5'd11;
    localparam logic [4:0] A_DESC_END    = 5'd12;
    localparam logic [4:0] A_PUSH        = 5'd13;
    localparam logic [4:0] A_BT_INIT     = 5'd14;
    localparam logic [4:0] A_BT_RD       = 5'd15;
    localparam logic [4:0] A_BT_TAKE     = 5'd16;
    localparam logic [4:0] A_BT_DEC      = 5'd17;
    localparam logic [4:0] A_EM_INIT     = 5'd18;
    localparam logic [4:0] A_EM_RD       = 5'd19;
    localparam logic [4:0] A_EM_OUT      = 5'd20;
    localparam logic [4:0] A_RESP        = 5'd21;

    typedef struct packed {
        logic [4:0] act;
        logic [2:0] resp;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       failed;
        logic       pd_full;
        logic       match;
        logic       s_last;
        logic       s_final;
        logic       cnt_end;
        logic       tgt_nz;
        logic       pathd_full;
        logic       n_full;
        logic       bt_none;
        logic       em_empty;
        logic       em_last;
        logic       out_free;
    } t_stat;

endpackage

// ----- rtl/apcs_ram.sv -----
// ----------------------------------------------------------------------------
// apcs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module apcs_ram #(
    parameter int AW = 12,
    parameter int DW = 30
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ----- rtl/apcs_dp.sv -----
// ----------------------------------------------------------------------------
// apcs_dp
// Datapath: entry store, path stack, depth/index registers, result register.
// ----------------------------------------------------------------------------
module apcs_dp import apcs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    input  logic [2:0]          i_op,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [LETTER_W-1:0] i_letter,
    input  logic [ADDR_W-1:0]   i_target,
    input  logic                i_last,
    input  logic                i_final,
    input  logic [LETTER_W-1:0] i_symbol,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [2:0]          o_status,
    output logic [LETTER_W-1:0] o_letter,
    output logic [POS_W-1:0]    o_position,
    output logic                o_last_of_run
);

    // captured word
    logic [2:0]          r_op;
    logic [ADDR_W-1:0]   r_waddr;
    logic [ENTRY_W-1:0]  r_wentry;
    logic [LETTER_W-1:0] r_sym;

    // walk state
    logic [DEPTH_W-1:0] r_pd, n_pd, r_pathd, n_pathd;
    logic [DEPTH_W-1:0] r_n, n_n, r_j, n_j, r_k, n_k;
    logic [ADDR_W-1:0]  r_e, n_e, r_cnt, n_cnt;
    logic               r_failed, n_failed;
    logic               r_p0_ok, r_pdflt;

    // result register
    logic                r_ovalid, n_ovalid;
    logic [2:0]          r_ostatus, n_ostatus;
    logic [LETTER_W-1:0] r_oletter, n_oletter;
    logic [POS_W-1:0]    r_opos, n_opos;
    logic                r_olast, n_olast;

    logic [ENTRY_W-1:0]  s_q;
    logic [LETTER_W-1:0] s_letter;
    logic [ADDR_W-1:0]   s_target;
    logic                s_last, s_final;

    logic               p_we;
    logic [PIDX_W-1:0]  p_waddr, p_raddr;
    logic [ADDR_W-1:0]  p_wdata, p_q, pdata;
    logic [DEPTH_W-1:0] m_depth;
    logic               out_free, out_load, em_last;

    assign s_letter = s_q[LETTER_W-1:0];
    assign s_target = s_q[LETTER_W+ADDR_W-1:LETTER_W];
    assign s_last   = s_q[LETTER_W+ADDR_W];
    assign s_final  = s_q[LETTER_W+ADDR_W+1];

    apcs_ram #(.AW(ADDR_W), .DW(ENTRY_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.act == A_WRITE),
        .i_waddr (r_waddr),
        .i_wdata (r_wentry),
        .i_raddr (r_e),
        .o_rdata (s_q)
    );

    always_comb begin
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = r_e;
        case (i_cmd.act)
            A_START: begin
                p_we    = 1'b1;
                p_wdata = ADDR_W'(1);
            end
            A_SCAN_MATCH: begin
                p_we    = 1'b1;
                p_waddr = r_pd[PIDX_W-1:0];
                p_wdata = s_target;
            end
            A_DESC_STEP: begin
                p_we    = 1'b1;
                p_waddr = r_n[PIDX_W-1:0];
            end
            default: ;
        endcase
    end

    assign m_depth = (r_pathd < r_pd) ? r_pd : r_pathd;

    always_comb begin
        case (i_cmd.act)
            A_RD_PD:  p_raddr = PIDX_W'(r_pd - DEPTH_W'(1));
            A_RD_TOP: p_raddr = PIDX_W'(m_depth - DEPTH_W'(1));
            A_BT_RD:  p_raddr = PIDX_W'(r_j - DEPTH_W'(1));
            A_EM_RD:  p_raddr = r_k[PIDX_W-1:0];
            default:  p_raddr = '0;
        endcase
    end

    apcs_ram #(.AW(PIDX_W), .DW(ADDR_W)) u_path (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_q)
    );

    // bottom of the path reads as block 1 until first written
    assign pdata = r_pdflt ? ADDR_W'(1) : p_q;

    assign out_free = !r_ovalid || i_ready;
    assign out_load = (i_cmd.act == A_EM_OUT) || (i_cmd.act == A_RESP);
    assign em_last  = (r_k + DEPTH_W'(2)) == r_pathd;

    always_comb begin
        n_pd      = r_pd;
        n_pathd   = r_pathd;
        n_n       = r_n;
        n_j       = r_j;
        n_k       = r_k;
        n_e       = r_e;
        n_cnt     = r_cnt;
        n_failed  = r_failed;
        n_ostatus = r_ostatus;
        n_oletter = r_oletter;
        n_opos    = r_opos;
        n_olast   = r_olast;
        case (i_cmd.act)
            A_START: begin
                n_pd     = DEPTH_W'(1);
                n_pathd  = DEPTH_W'(1);
                n_failed = 1'b0;
            end
            A_SETFAIL:     n_failed = 1'b1;
            A_RD_PD:       n_n = r_pd - DEPTH_W'(1);
            A_RD_TOP:      n_pathd = m_depth;
            A_E_PDATA: begin
                n_e   = pdata;
                n_cnt = '0;
            end
            A_SCAN_MATCH: begin
                n_pd    = r_pd + DEPTH_W'(1);
                n_pathd = r_pd + DEPTH_W'(1);
            end
            A_SCAN_NEXT: begin
                n_e   = r_e + ADDR_W'(1);
                n_cnt = r_cnt + ADDR_W'(1);
            end
            A_DESC_STEP:   n_n = r_n + DEPTH_W'(1);
            A_DESC_FOLLOW: n_e = s_target;
            A_DESC_END:    n_pathd = r_n;
            A_PUSH: begin
                n_e = s_target;
                n_n = r_pathd;
            end
            A_BT_INIT:     n_j = r_pathd - DEPTH_W'(1);
            A_BT_TAKE: begin
                n_e = r_e + ADDR_W'(1);
                n_n = r_j - DEPTH_W'(1);
            end
            A_BT_DEC:      n_j = r_j - DEPTH_W'(1);
            A_EM_INIT:     n_k = r_pd - DEPTH_W'(1);
            A_EM_OUT: begin
                n_k       = r_k + DEPTH_W'(1);
                n_ostatus = ST_LETTER;
                n_oletter = s_letter;
                n_opos    = POS_W'(r_k - r_pd + DEPTH_W'(1));
                n_olast   = em_last;
            end
            A_RESP: begin
                n_ostatus = i_cmd.resp;
                n_oletter = '0;
                n_opos    = (i_cmd.resp == ST_NOTFOUND) ? POS_W'(r_pd) : '0;
                n_olast   = 1'b1;
            end
            default: ;
        endcase
        n_ovalid = out_load ? 1'b1 : (i_ready ? 1'b0 : r_ovalid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pd     <= DEPTH_W'(1);
            r_pathd  <= DEPTH_W'(1);
            r_failed <= 1'b0;
            r_p0_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pd     <= n_pd;
            r_pathd  <= n_pathd;
            r_failed <= n_failed;
            r_ovalid <= n_ovalid;
            if (p_we && p_waddr == '0) begin
                r_p0_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_n       <= n_n;
        r_j       <= n_j;
        r_k       <= n_k;
        r_e       <= n_e;
        r_cnt     <= n_cnt;
        r_ostatus <= n_ostatus;
        r_oletter <= n_oletter;
        r_opos    <= n_opos;
        r_olast   <= n_olast;
        r_pdflt   <= (p_raddr == '0) && !r_p0_ok;
        if (i_cmd.act == A_LOAD) begin
            r_op     <= i_op;
            r_waddr  <= i_addr;
            r_wentry <= {i_final, i_last, i_target, i_letter};
            r_sym    <= i_symbol;
        end
    end

    always_comb begin
        o_stat            = '0;
        o_stat.op         = r_op;
        o_stat.failed     = r_failed;
        o_stat.pd_full    = r_pd == DEPTH_W'(DEPTH);
        o_stat.match      = s_letter == r_sym;
        o_stat.s_last     = s_last;
        o_stat.s_final    = s_final;
        o_stat.cnt_end    = &r_cnt;
        o_stat.tgt_nz     = s_target != '0;
        o_stat.pathd_full = r_pathd == DEPTH_W'(DEPTH);
        o_stat.n_full     = r_n == DEPTH_W'(DEPTH);
        o_stat.bt_none    = r_j < r_pd;
        o_stat.em_empty   = r_pathd == r_pd;
        o_stat.em_last    = em_last;
        o_stat.out_free   = out_free;
    end

    assign o_valid       = r_ovalid;
    assign o_status      = r_ostatus;
    assign o_letter      = r_oletter;
    assign o_position    = r_opos;
    assign o_last_of_run = r_olast;

    a_pd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pd >= DEPTH_W'(1) && r_pd <= DEPTH_W'(DEPTH))
        else $error("prefix depth out of range");
    a_pathd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pathd <= DEPTH_W'(DEPTH))
        else $error("path depth beyond stack");
    a_push_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.act == A_DESC_STEP |-> r_n < DEPTH_W'(DEPTH))
        else $error("descend writes past top of path stack");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> out_free)
        else $error("result register overwritten while held");

endmodule

// ----- rtl/apcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// apcs_ctrl
// Controller: sequences block scans, descents, backtracking and letter output.
// ----------------------------------------------------------------------------
module apcs_ctrl import apcs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DEC    = 5'd1;
    localparam logic [4:0] S_RESP   = 5'd2;
    localparam logic [4:0] S_SCAN_P = 5'd3;
    localparam logic [4:0] S_SCAN_W = 5'd4;
    localparam logic [4:0] S_SCAN_C = 5'd5;
    localparam logic [4:0] S_DESC_P = 5'd6;
    localparam logic [4:0] S_DESC_R = 5'd7;
    localparam logic [4:0] S_DESC_C = 5'd8;
    localparam logic [4:0] S_NX_P   = 5'd9;
    localparam logic [4:0] S_NX_W   = 5'd10;
    localparam logic [4:0] S_NX_C   = 5'd11;
    localparam logic [4:0] S_BT_A   = 5'd12;
    localparam logic [4:0] S_BT_P   = 5'd13;
    localparam logic [4:0] S_BT_W   = 5'd14;
    localparam logic [4:0] S_BT_C   = 5'd15;
    localparam logic [4:0] S_EM0    = 5'd16;
    localparam logic [4:0] S_EM_A   = 5'd17;
    localparam logic [4:0] S_EM_P   = 5'd18;
    localparam logic [4:0] S_EM_W   = 5'd19;
    localparam logic [4:0] S_EM_O   = 5'd20;

    logic [4:0] r_state, n_state;
    logic [2:0] r_resp, n_resp;

    assign o_ready = r_state == S_IDLE;

    always_comb begin
        n_state    = r_state;
        n_resp     = r_resp;
        o_cmd.act  = A_NONE;
        o_cmd.resp = r_resp;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.act = A_LOAD;
                    n_state   = S_DEC;
                end
            end
            S_DEC: begin
                n_resp  = ST_OK;
                n_state = S_RESP;
                case (i_stat.op)
                    OP_WRITE: o_cmd.act = A_WRITE;
                    OP_START: o_cmd.act = A_START;
                    OP_SYMBOL: begin
                        if (i_stat.failed) begin
                            n_resp = ST_NOTFOUND;
                        end else if (i_stat.pd_full) begin
                            o_cmd.act = A_SETFAIL;
                            n_resp    = ST_NOTFOUND;
                        end else begin
                            o_cmd.act = A_RD_PD;
                            n_state   = S_SCAN_P;
                        end
                    end
                    OP_FIRST: begin
                        if (i_stat.failed) begin
                            n_resp = ST_NOTFOUND;
                        end else begin
                            o_cmd.act = A_RD_PD;
                            n_state   = S_DESC_P;
                        end
                    end
                    OP_NEXT: begin
                        if (i_stat.failed) begin
                            n_resp = ST_NOTFOUND;
                        end else begin
                            o_cmd.act = A_RD_TOP;
                            n_state   = S_NX_P;
                        end
                    end
                    default: ;
                endcase
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.act = A_RESP;
                    n_state   = S_IDLE;
                end
            end
            S_SCAN_P: begin
                o_cmd.act = A_E_PDATA;
                n_state   = S_SCAN_W;
            end
            S_SCAN_W: n_state = S_SCAN_C;
            S_SCAN_C: begin
                if (i_stat.match) begin
                    o_cmd.act = A_SCAN_MATCH;
                    n_resp    = ST_OK;
                    n_state   = S_RESP;
                end else if (i_stat.s_last || i_stat.cnt_end) begin
                    o_cmd.act = A_SETFAIL;
                    n_resp    = ST_NOTFOUND;
                    n_state   = S_RESP;
                end else begin
                    o_cmd.act = A_SCAN_NEXT;
                    n_state   = S_SCAN_W;
                end
            end
            S_DESC_P: begin
                o_cmd.act = A_E_PDATA;
                n_state   = S_DESC_R;
            end
            S_DESC_R: begin
                o_cmd.act = A_DESC_STEP;
                n_state   = S_DESC_C;
            end
            S_DESC_C: begin
                if (i_stat.s_final || i_stat.n_full) begin
                    o_cmd.act = A_DESC_END;
                    n_state   = S_EM0;
                end else begin
                    o_cmd.act = A_DESC_FOLLOW;
                    n_state   = S_DESC_R;
                end
            end
            S_NX_P: begin
                o_cmd.act = A_E_PDATA;
                n_state   = S_NX_W;
            end
            S_NX_W: n_state = S_NX_C;
            S_NX_C: begin
                if (i_stat.tgt_nz && !i_stat.pathd_full) begin
                    o_cmd.act = A_PUSH;
                    n_state   = S_DESC_R;
                end else begin
                    o_cmd.act = A_BT_INIT;
                    n_state   = S_BT_A;
                end
            end
            S_BT_A: begin
                if (i_stat.bt_none) begin
                    n_resp  = ST_NOMORE;
                    n_state = S_RESP;
                end else begin
                    o_cmd.act = A_BT_RD;
                    n_state   = S_BT_P;
                end
            end
            S_BT_P: begin
                o_cmd.act = A_E_PDATA;
                n_state   = S_BT_W;
            end
            S_BT_W: n_state = S_BT_C;
            S_BT_C: begin
                if (!i_stat.s_last) begin
                    o_cmd.act = A_BT_TAKE;
                    n_state   = S_DESC_R;
                end else begin
                    o_cmd.act = A_BT_DEC;
                    n_state   = S_BT_A;
                end
            end
            S_EM0: begin
                if (i_stat.em_empty) begin
                    n_resp  = ST_EMPTY;
                    n_state = S_RESP;
                end else begin
                    o_cmd.act = A_EM_INIT;
                    n_state   = S_EM_A;
                end
            end
            S_EM_A: begin
                o_cmd.act = A_EM_RD;
                n_state   = S_EM_P;
            end
            S_EM_P: begin
                o_cmd.act = A_E_PDATA;
                n_state   = S_EM_W;
            end
            S_EM_W: n_state = S_EM_O;
            S_EM_O: begin
                if (i_stat.out_free) begin
                    o_cmd.act = A_EM_OUT;
                    n_state   = i_stat.em_last ? S_IDLE : S_EM_A;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_resp  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_resp  <= n_resp;
        end
    end

endmodule

// ----- rtl/automaton_prefix_completion_scan.sv -----
// ----------------------------------------------------------------------------
// automaton_prefix_completion_scan
// Prefix match and completion enumeration over a word automaton entry store.
//
//   channel  dir  signals                           content
//   s        in   i_s_tvalid/o_s_tready/tdata/tuser  one operation word
//   m        out  o_m_tvalid/i_m_tready/tdata/tuser/tlast  result words
//
// One word is taken at a time. Write and start ops update state and then answer;
// failed-query and unknown ops only answer. A prefix symbol scans the block's
// entries one by one, each waiting on the registered store read. First
// completion descends level by level; next completion descends or backtracks
// entry by entry to a sibling. Then one result word per letter, or a single word
// for an empty or exhausted word. Reset leaves the store undefined; no clearing pass.
// A stalled output only holds the walk at the point where a word is due.
// ----------------------------------------------------------------------------
module automaton_prefix_completion_scan import apcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: entry_address[11:0], entry_letter[27:12], entry_target[39:28],
    //        entry_last[40], entry_final[41], symbol[57:42], zero[63:58]
    input  logic [63:0] i_s_tdata,
    // tuser: operation[2:0]
    input  logic [2:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: letter[15:0], position[22:16], zero[23]
    output logic [23:0] o_m_tdata,
    // tuser: status[2:0]
    output logic [2:0]  o_m_tuser,
    output logic        o_m_tlast
);

    t_cmd  cmd;
    t_stat stat;

    logic [LETTER_W-1:0] letter;
    logic [POS_W-1:0]    position;

    apcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    apcs_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_op          (i_s_tuser),
        .i_addr        (i_s_tdata[11:0]),
        .i_letter      (i_s_tdata[27:12]),
        .i_target      (i_s_tdata[39:28]),
        .i_last        (i_s_tdata[40]),
        .i_final       (i_s_tdata[41]),
        .i_symbol      (i_s_tdata[57:42]),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_status      (o_m_tuser),
        .o_letter      (letter),
        .o_position    (position),
        .o_last_of_run (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, position, letter};

endmodule

// ----- sim/automaton_prefix_completion_scan_test.sv -----
// ----------------------------------------------------------------------------
// automaton_prefix_completion_scan_test
// Self-checking bench: builds small random tries plus one deep single-letter
// chain, then runs prefix queries and completion walks against a
// cycle-free predictor.
// Ops that would touch a never-written entry are screened out before they
// are queued.
// ----------------------------------------------------------------------------
module automaton_prefix_completion_scan_test;
    timeunit 1ns;
    timeprecision 1ps;
    import apcs_pkg::*;

    localparam int          ENTRIES      = 4096;
    localparam logic [11:0] CHAIN_BASE   = 12'd3000;
    localparam logic [15:0] CHAIN_LETTER = 16'h007a;
    localparam logic [2:0]  OP_RSV_FIRST = 3'd5;   // reserved codes, acked only
    localparam logic [2:0]  OP_RSV_LAST  = 3'd7;
    localparam int          RANDOM_ITEMS = 330;
    localparam int          CYCLE_LIMIT  = 600000;

    typedef struct packed {
        logic [2:0]  op;
        logic [11:0] addr;
        logic [15:0] letter;
        logic [11:0] target;
        logic        last;
        logic        final_f;
        logic [15:0] sym;
    } op_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] letter;
        logic [6:0]  pos;
        logic        tlast;
    } res_word_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [63:0] i_s_tdata = '0;
    logic [2:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [23:0] o_m_tdata;
    logic [2:0]  o_m_tuser;
    logic        o_m_tlast;

    automaton_prefix_completion_scan DUT (.*);

    always #10 i_clk = ~i_clk;

    // ---------------- predictor state ----------------
    logic [15:0] trie_letter [ENTRIES];
    logic [11:0] trie_target [ENTRIES];
    bit          trie_last   [ENTRIES];
    bit          trie_final  [ENTRIES];
    bit          trie_written[ENTRIES];
    logic [11:0] walk_path   [DEPTH];
    int          prefix_len;
    int          walk_len;
    bit          query_dead;
    bit          touched_unwritten;

    op_word_t  word_q[$];
    res_word_t due_tmp[$];
    res_word_t results_due[$];
    int        errors = 0;
    int        cycles = 0;
    bit        stim_done = 0;

    function automatic void touch(logic [11:0] e);
        if (!trie_written[e]) touched_unwritten = 1;
    endfunction

    function automatic void post(logic [2:0] st, logic [15:0] l, int p, bit t);
        res_word_t r;
        r.status = st; r.letter = l; r.pos = 7'(p); r.tlast = t;
        due_tmp.push_back(r);
    endfunction

    function automatic int descend(int n);
        logic [11:0] e;
        e = walk_path[n];
        forever begin
            walk_path[n] = e;
            n++;
            touch(e);
            if (trie_final[e] || n >= DEPTH) break;
            e = trie_target[e];
        end
        return n;
    endfunction

    function automatic void emit_suffix();
        int cnt;
        cnt = walk_len - prefix_len;
        if (cnt == 0) post(ST_EMPTY, '0, 0, 1);
        for (int k = 0; k < cnt; k++)
            post(ST_LETTER, trie_letter[walk_path[prefix_len - 1 + k]], k, k + 1 == cnt);
    endfunction

    function automatic void predict(op_word_t w);
        logic [11:0] e;
        logic [11:0] top;
        if (w.op == OP_WRITE) begin
            trie_letter[w.addr] = w.letter; trie_target[w.addr] = w.target;
            trie_last[w.addr] = w.last; trie_final[w.addr] = w.final_f;
            trie_written[w.addr] = 1;
            post(ST_OK, '0, 0, 1);
        end else if (w.op == OP_START) begin
            walk_path[0] = 12'd1; prefix_len = 1; walk_len = 1; query_dead = 0;
            post(ST_OK, '0, 0, 1);
        end else if (w.op inside {OP_SYMBOL, OP_FIRST, OP_NEXT} && query_dead) begin
            post(ST_NOTFOUND, '0, prefix_len, 1);
        end else if (w.op == OP_SYMBOL) begin
            if (prefix_len < DEPTH) begin
                e = walk_path[prefix_len - 1];
                for (int n = 0; n < ENTRIES && !touched_unwritten; n++) begin
                    touch(e);
                    if (trie_letter[e] == w.sym) begin
                        walk_path[prefix_len] = trie_target[e];
                        prefix_len++; walk_len = prefix_len;
                        post(ST_OK, '0, 0, 1);
                        return;
                    end
                    if (trie_last[e]) break;
                    e = e + 12'd1;
                end
            end
            query_dead = 1;
            post(ST_NOTFOUND, '0, prefix_len, 1);
        end else if (w.op == OP_FIRST) begin
            walk_len = descend(prefix_len - 1);
            emit_suffix();
        end else if (w.op == OP_NEXT) begin
            if (walk_len < prefix_len) walk_len = prefix_len;
            top = walk_path[walk_len - 1];
            touch(top);
            if (trie_target[top] != 0 && walk_len < DEPTH) begin
                walk_path[walk_len] = trie_target[top];
                walk_len = descend(walk_len);
                emit_suffix();
                return;
            end
            // backtrack to the deepest entry that still has a sibling
            for (int i = walk_len - 2; i >= prefix_len - 1; i--) begin
                e = walk_path[i];
                touch(e);
                if (trie_last[e]) continue;
                walk_path[i] = e + 12'd1;
                walk_len = descend(i);
                emit_suffix();
                return;
            end
            post(ST_NOMORE, '0, 0, 1);
        end else begin
            post(ST_OK, '0, 0, 1);
        end
    endfunction

    // queue a word unless it would read a never-written entry
    task automatic queue_word(op_word_t w);
        logic [11:0] saved_path[DEPTH];
        int sp, sw;
        bit sd;
        saved_path = walk_path; sp = prefix_len; sw = walk_len; sd = query_dead;
        touched_unwritten = 0;
        due_tmp.delete();
        predict(w);
        if (touched_unwritten) begin
            walk_path = saved_path; prefix_len = sp; walk_len = sw; query_dead = sd;
        end else begin
            word_q.push_back(w);
            foreach (due_tmp[k]) results_due.push_back(due_tmp[k]);
        end
    endtask

    function automatic op_word_t noise_word(logic [2:0] op);
        op_word_t w;
        w.op = op;
        w.addr = 12'($urandom); w.letter = 16'($urandom); w.target = 12'($urandom);
        w.last = 1'($urandom); w.final_f = 1'($urandom); w.sym = 16'($urandom);
        return w;
    endfunction

    task automatic send_op(logic [2:0] op, logic [15:0] sym);
        op_word_t w;
        w = noise_word(op);
        w.sym = sym;
        queue_word(w);
    endtask

    task automatic write_entry(logic [11:0] a, logic [15:0] l, logic [11:0] t,
                               bit lst, bit fin);
        op_word_t w;
        w = noise_word(OP_WRITE);
        w.addr = a; w.letter = l; w.target = t; w.last = lst; w.final_f = fin;
        queue_word(w);
    endtask

    // root block at 1 ends with a gate entry leading into the deep chain
    task automatic build_trie();
        int blk_start[$], blk_size[$], blk_level[$];
        int next_free, s, z, lv, csz;
        logic [11:0] tgt;
        bit fin;
        z = $urandom_range(2, 4);
        next_free = 1 + z;
        blk_start.push_back(1); blk_size.push_back(z); blk_level.push_back(0);
        while (blk_start.size() > 0) begin
            s = blk_start.pop_front(); z = blk_size.pop_front(); lv = blk_level.pop_front();
            for (int i = 0; i < z; i++) begin
                if (lv == 0 && i == z - 1) begin
                    write_entry(12'(s + i), CHAIN_LETTER, CHAIN_BASE, 1, 0);
                    continue;
                end
                tgt = '0;
                if (lv < 3 && $urandom_range(0, 2) != 0) begin
                    csz = $urandom_range(1, 3);
                    tgt = 12'(next_free);
                    blk_start.push_back(next_free); blk_size.push_back(csz);
                    blk_level.push_back(lv + 1);
                    next_free += csz;
                end
                fin = (tgt == 0) ? 1'b1 : 1'($urandom);
                write_entry(12'(s + i), 16'($urandom), tgt, i == z - 1, fin);
            end
        end
    endtask

    function automatic logic [15:0] pick_symbol();
        logic [15:0] seen[$];
        logic [11:0] e;
        if (query_dead || prefix_len >= DEPTH || $urandom_range(0, 9) == 0)
            return 16'($urandom);
        e = walk_path[prefix_len - 1];
        for (int n = 0; n < 8 && trie_written[e]; n++) begin
            seen.push_back(trie_letter[e]);
            if (trie_last[e]) break;
            e = e + 12'd1;
        end
        if (seen.size() == 0) return 16'($urandom);
        return seen[$urandom_range(0, seen.size() - 1)];
    endfunction

    task automatic run_query();
        send_op(OP_START, '0);
        repeat ($urandom_range(0, 3)) send_op(OP_SYMBOL, pick_symbol());
        if ($urandom_range(0, 5) != 0) send_op(OP_FIRST, '0);
        repeat ($urandom_range(0, 5)) send_op(OP_NEXT, '0);
    endtask

    initial begin
        int r;
        foreach (trie_written[k]) trie_written[k] = 0;
        walk_path[0] = 12'd1; prefix_len = 1; walk_len = 1; query_dead = 0;

        write_entry(12'd0, 16'h0000, 12'd0, 1, 1);
        for (int j = 0; j < DEPTH; j++)
            write_entry(CHAIN_BASE + 12'(j), CHAIN_LETTER,
                        (j < DEPTH - 1) ? CHAIN_BASE + 12'(j + 1) : 12'd0, 1, 0);
        build_trie();

        // directed
        send_op(OP_START, '0);
        send_op(OP_NEXT, '0);                          // next before any first
        send_op(OP_FIRST, '0);
        repeat (4) send_op(OP_NEXT, '0);
        send_op(OP_RSV_FIRST, 16'hffff);
        send_op(OP_RSV_LAST, 16'h0000);
        send_op(OP_SYMBOL, 16'hffff);                  // no such letter
        send_op(OP_SYMBOL, CHAIN_LETTER);              // dead query stays dead
        send_op(OP_FIRST, '0);
        send_op(OP_NEXT, '0);
        send_op(OP_START, '0);
        send_op(OP_SYMBOL, CHAIN_LETTER);
        send_op(OP_FIRST, '0);                         // cut at the depth limit
        send_op(OP_NEXT, '0);
        send_op(OP_NEXT, '0);                          // exhausted twice
        write_entry(12'hfff, 16'hffff, 12'hfff, 1, 1);
        write_entry(12'hffe, 16'h0000, 12'h000, 0, 0);

        while (word_q.size() < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 68) run_query();
            else if (r < 78) begin
                op_word_t w;
                w = noise_word(OP_WRITE);
                if ($urandom_range(0, 1)) w.addr = 12'($urandom_range(1, 40));
                queue_word(w);
            end else if (r < 83) queue_word(noise_word(3'($urandom_range(OP_RSV_LAST,
                                                                        OP_RSV_FIRST))));
            else if (r < 87) build_trie();
            else if (r < 90) begin
                // prefix deeper than the path stack holds
                send_op(OP_START, '0);
                repeat (DEPTH) send_op(OP_SYMBOL, CHAIN_LETTER);
                send_op(OP_FIRST, '0);
            end else begin
                r = $urandom_range(0, 2);
                if (r == 0) send_op(OP_SYMBOL, pick_symbol());
                else if (r == 1) send_op(OP_FIRST, '0);
                else send_op(OP_NEXT, '0);
            end
        end
        stim_done = 1;
    end

    // ---------------- reset, idling ----------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    function automatic bit go_idle();
        if (cycles > 1600 && cycles < 2600) return 0;
        return $urandom_range(0, 99) < 12;
    endfunction

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (word_q.size() > 0 && !go_idle()) begin
                op_word_t w;
                w = word_q.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= {6'd0, w.sym, w.final_f, w.last, w.target, w.letter, w.addr};
                i_s_tuser  <= w.op;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with one long hold-off so the block backs up
    int hold_left = 0;
    always @(posedge i_clk) begin
        if (cycles == 1000) hold_left = 400;
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n && !go_idle();
        end
    end

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            res_word_t want;
            res_word_t got;
            got = {o_m_tuser, o_m_tdata[15:0], o_m_tdata[22:16], o_m_tlast};
            if (results_due.size() == 0) begin
                errors++;
                $display("%t unexpected word: expected none actual %h", $realtime, got);
            end else begin
                want = results_due.pop_front();
                if (got.status !== want.status) begin
                    errors++;
                    $display("%t status: expected %0d actual %0d", $realtime, want.status,
                             got.status);
                end
                if (got.letter !== want.letter) begin
                    errors++;
                    $display("%t letter: expected %h actual %h", $realtime, want.letter,
                             got.letter);
                end
                if (got.pos !== want.pos) begin
                    errors++;
                    $display("%t position: expected %0d actual %0d", $realtime, want.pos,
                             got.pos);
                end
                if (got.tlast !== want.tlast) begin
                    errors++;
                    $display("%t tlast: expected %0d actual %0d", $realtime, want.tlast,
                             got.tlast);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        wait (stim_done);
        do @(posedge i_clk);
        while (word_q.size() > 0 || i_s_tvalid || results_due.size() > 0);
        repeat (300) @(posedge i_clk);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/apcs_pkg.sv
rtl/apcs_ram.sv
rtl/apcs_dp.sv
rtl/apcs_ctrl.sv
rtl/automaton_prefix_completion_scan.sv
sim/automaton_prefix_completion_scan_test.sv
